// ===== rtl/sgm_pkg.sv =====
package sgm_pkg;

  localparam int CHANNELS   = 8;
  localparam int COUNT_BITS = 32;
  localparam int CHAN_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ID_W       = 8;
  localparam int SEQ_W      = 8;
  localparam int OUT_W      = 32;
  localparam int NUM_W      = 4;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [CHAN_W-1:0]     chan_t;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_t;

  // scanner result, valid for one cycle when done is set
  typedef struct packed {
    logic  done;
    logic  found;
    chan_t chan;
  } scan_res_t;

  // channel memory write port
  typedef struct packed {
    logic             en;
    chan_t            addr;
    logic [SEQ_W-1:0] seq;
    cnt_t             recv;
    cnt_t             missed;
  } ram_wr_t;

  // channel memory read data
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    cnt_t             recv;
    cnt_t             missed;
  } ram_rd_t;

  // saturating add of a narrow increment
  function automatic cnt_t sat_add(cnt_t a, logic [SEQ_W-1:0] b);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, a} + (COUNT_BITS+1)'(b);
    if (sum[COUNT_BITS]) begin
      return {COUNT_BITS{1'b1}};
    end
    return sum[COUNT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/sgm_scan.sv =====
module sgm_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sgm_pkg::ID_W-1:0]      rid,
  input  logic [sgm_pkg::NUM_W-1:0]     act,
  input  logic [63:0]                   ids,
  output sgm_pkg::scan_res_t            res
);
  import sgm_pkg::*;

  logic  busy_r, busy_nxt;
  chan_t idx_r, idx_nxt;
  logic  hit_now;
  logic  last_now;

  // compare one table entry per cycle
  always_comb begin
    hit_now  = (NUM_W'(idx_r) < act) && (ids[{idx_r, 3'b000} +: ID_W] == rid);
    last_now = hit_now || (idx_r == CHAN_W'(CHANNELS - 1));
    res.done  = busy_r && last_now;
    res.found = hit_now;
    res.chan  = idx_r;
  end

  // entry counter
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (last_now) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

// ===== rtl/sgm_chan_ram.sv =====
module sgm_chan_ram (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  sgm_pkg::chan_t       rd_addr,
  output sgm_pkg::ram_rd_t     rd_data,
  input  sgm_pkg::ram_wr_t     wr,
  input  logic                 clear
);
  import sgm_pkg::*;

  logic [SEQ_W-1:0]      seq_mem [CHANNELS];
  logic [2*COUNT_BITS-1:0] cnt_mem [CHANNELS];

  logic [CHANNELS-1:0]   seq_vld_r;
  logic [CHANNELS-1:0]   cnt_vld_r;

  logic [SEQ_W-1:0]      seq_q_r;
  logic [2*COUNT_BITS-1:0] cnt_q_r;
  logic                  seq_ok_r;
  logic                  cnt_ok_r;

  // memory arrays
  always_ff @(posedge clk) begin
    if (wr.en) begin
      seq_mem[wr.addr] <= wr.seq;
      cnt_mem[wr.addr] <= {wr.recv, wr.missed};
    end
    if (rd_en) begin
      seq_q_r <= seq_mem[rd_addr];
      cnt_q_r <= cnt_mem[rd_addr];
    end
  end

  // entry valid bits: unwritten entries read zero; clear resets only counter bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_vld_r <= '0;
      cnt_vld_r <= '0;
      seq_ok_r  <= 1'b0;
      cnt_ok_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        seq_vld_r[wr.addr] <= 1'b1;
      end
      if (clear) begin
        cnt_vld_r <= '0;
      end else if (wr.en) begin
        cnt_vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        seq_ok_r <= seq_vld_r[rd_addr];
        cnt_ok_r <= cnt_vld_r[rd_addr];
      end
    end
  end

  // masked read data
  always_comb begin
    rd_data.seq    = seq_ok_r ? seq_q_r : '0;
    rd_data.recv   = cnt_ok_r ? cnt_q_r[2*COUNT_BITS-1:COUNT_BITS] : '0;
    rd_data.missed = cnt_ok_r ? cnt_q_r[COUNT_BITS-1:0] : '0;
  end

endmodule

// ===== rtl/sequence_gap_channel_monitor_unit.sv =====
// channel   | ports                                             | direction
// ----------+---------------------------------------------------+----------
// input     | in_valid, in_stall, in_cmd, in_report_id,         | in
//           | in_seq_num, in_read_index                         |
// result    | out_valid, out_stall, out_hit, out_channel,       | out
//           | out_duplicate, out_missed_now, out_received,      |
//           | out_missed_sum, out_events_seen                   |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,     | in/out
//           | pready (num_channels at 0x0, channel_ids at 0x8)  |
//
// an event runs from accept through the identifier scan, which checks the table
// entries in order, the last one issuing the memory read if the identifier is found,
// then the update step; clear, read and no-op beats skip the scan; one beat is in
// flight at a time; the next beat can be taken once the result is presented
// reset is synchronous and zeroes all counters at once via entry valid bits
// a result stalled at the output holds the update step until it is taken
module sequence_gap_channel_monitor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_report_id,
  input  logic [7:0]  in_seq_num,
  input  logic [2:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [2:0]  out_channel,
  output logic        out_duplicate,
  output logic [7:0]  out_missed_now,
  output logic [31:0] out_received,
  output logic [31:0] out_missed_sum,
  output logic [31:0] out_events_seen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import sgm_pkg::*;

  // config registers
  logic [NUM_W-1:0] num_ch_r;
  logic [63:0]      ids_r;
  logic [NUM_W-1:0] act;

  // item registers
  state_t           state_r, state_nxt;
  cmd_t             cmd_r;
  logic [ID_W-1:0]  rid_r;
  logic [SEQ_W-1:0] seq_r;
  logic [2:0]       ridx_r;
  logic             found_r;
  chan_t            chan_r;
  cnt_t             event_total_r;

  // output registers
  logic             out_valid_r;
  logic             out_hit_r;
  logic [2:0]       out_channel_r;
  logic             out_dup_r;
  logic [7:0]       out_mnow_r;
  logic [OUT_W-1:0] out_recv_r;
  logic [OUT_W-1:0] out_msum_r;
  logic [OUT_W-1:0] out_evt_r;

  // fsm outputs
  logic             accept;
  logic             scan_start;
  logic             rd_en;
  chan_t            rd_addr;
  logic             upd_fire;
  logic             out_free;

  scan_res_t        scan_res;
  ram_rd_t          rd_data;
  ram_wr_t          wr;
  logic             mem_clear;

  // update datapath
  logic             res_hit;
  logic             res_dup;
  logic [SEQ_W-1:0] res_gap;
  cnt_t             new_recv;
  cnt_t             new_missed;
  cnt_t             res_recv;
  cnt_t             res_msum;
  cnt_t             evt_nxt;

  // config port
  assign pready = 1'b1;
  assign act    = (num_ch_r > NUM_W'(CHANNELS)) ? NUM_W'(CHANNELS) : num_ch_r;

  always_comb begin
    prdata = paddr[3] ? ids_r : 64'(num_ch_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r <= '0;
      ids_r    <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        ids_r <= pwdata;
      end else begin
        num_ch_r <= pwdata[NUM_W-1:0];
      end
    end
  end

  // identifier scanner
  sgm_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .rid   (rid_r),
    .act   (act),
    .ids   (ids_r),
    .res   (scan_res)
  );

  // per-channel state memory
  sgm_chan_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .clear   (mem_clear)
  );

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (cmd_t'(in_cmd) == CMD_EVENT) ? ST_SCAN : ST_UPD;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall   = 1'b1;
    accept     = 1'b0;
    scan_start = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = in_read_index[CHAN_W-1:0];
    upd_fire   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        accept     = in_valid;
        scan_start = in_valid && (cmd_t'(in_cmd) == CMD_EVENT);
        rd_en      = in_valid && (cmd_t'(in_cmd) == CMD_READ);
      end
      ST_SCAN: begin
        rd_en   = scan_res.done && scan_res.found;
        rd_addr = scan_res.chan;
      end
      ST_UPD: begin
        upd_fire = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_cmd);
      rid_r  <= in_report_id;
      seq_r  <= in_seq_num;
      ridx_r <= in_read_index;
    end
    if (scan_res.done) begin
      chan_r <= scan_res.chan;
    end
  end

  // update step: gap, saturating counters, result fields
  always_comb begin
    res_dup    = (rd_data.seq == seq_r);
    res_gap    = seq_r - rd_data.seq - 1'b1;
    new_recv   = sat_add(rd_data.recv, SEQ_W'(1));
    new_missed = sat_add(rd_data.missed, res_gap);
    res_hit    = 1'b0;
    res_recv   = '0;
    res_msum   = '0;
    evt_nxt    = event_total_r;
    wr.en      = 1'b0;
    wr.addr    = chan_r;
    wr.seq     = seq_r;
    wr.recv    = new_recv;
    wr.missed  = new_missed;
    mem_clear  = 1'b0;
    case (cmd_r)
      CMD_EVENT: begin
        res_hit = found_r;
        if (found_r) begin
          evt_nxt  = sat_add(event_total_r, SEQ_W'(1));
          res_recv = res_dup ? rd_data.recv : new_recv;
          res_msum = res_dup ? rd_data.missed : new_missed;
          wr.en    = upd_fire && !res_dup;
        end
      end
      CMD_CLEAR: begin
        evt_nxt   = '0;
        mem_clear = upd_fire;
      end
      CMD_READ: begin
        res_hit = (NUM_W'(ridx_r) < act);
        if (res_hit) begin
          res_recv = rd_data.recv;
          res_msum = rd_data.missed;
        end
      end
      default: begin
        evt_nxt = event_total_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      found_r       <= 1'b0;
      event_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        found_r <= 1'b0;
      end else if (scan_res.done) begin
        found_r <= scan_res.found;
      end
      if (upd_fire) begin
        event_total_r <= evt_nxt;
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_hit_r     <= res_hit;
      out_dup_r     <= (cmd_r == CMD_EVENT) && found_r && res_dup;
      out_mnow_r    <= ((cmd_r == CMD_EVENT) && found_r && !res_dup) ? res_gap : '0;
      out_recv_r    <= OUT_W'(res_recv);
      out_msum_r    <= OUT_W'(res_msum);
      out_evt_r     <= OUT_W'(evt_nxt);
      case (cmd_r)
        CMD_EVENT: out_channel_r <= found_r ? 3'(chan_r) : 3'd0;
        CMD_READ:  out_channel_r <= ridx_r;
        default:   out_channel_r <= 3'd0;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_channel     = out_channel_r;
  assign out_duplicate   = out_dup_r;
  assign out_missed_now  = out_mnow_r;
  assign out_received    = out_recv_r;
  assign out_missed_sum  = out_msum_r;
  assign out_events_seen = out_evt_r;

  // a completed update always presents a result next cycle
  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire |=> out_valid_r)
    else $error("update completed without result");

  // a duplicate never counts a gap
  a_dup_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dup_r) |-> (out_mnow_r == '0))
    else $error("duplicate with nonzero gap");

  // a miss returns no counters
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_recv_r == '0 && out_msum_r == '0))
    else $error("counters returned on miss");

  // a clear zeroes the global event count
  a_clear_evt: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && cmd_r == CMD_CLEAR) |=> (event_total_r == '0))
    else $error("event count not cleared");

  // no new beat is taken while an item is still in the scan or update
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_UPD) |-> in_stall)
    else $error("beat accepted while busy");

endmodule
